// ===== hdl/pipt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipt_pkg
// Shared types and constants of the point-in-polygon test unit.
// ----------------------------------------------------------------------------
package pipt_pkg;

	localparam int XW   = 29;          // longitude width
	localparam int YW   = 28;          // latitude width
	localparam int CFGW = 5;           // vertex_count width
	localparam int IDXW = 4;           // vertex_index width
	localparam int DXW  = XW + 1;      // x difference width
	localparam int DYW  = YW + 1;      // y difference width
	localparam int PW   = DXW + DYW;   // cross product width

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [YW-1:0] y;
	} vertex_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} tok_t;

	typedef struct packed {
		logic fin;
		logic strobe;
		logic hit;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/pipt_vertex_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipt_vertex_mem
// Polygon vertex store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pipt_vertex_mem
	import pipt_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire vertex_t       wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output vertex_t            rd_data
);

	vertex_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/pipt_edge_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipt_edge_pipe
// Edge crossing pipeline: differences, cross products, compare and parity.
// ----------------------------------------------------------------------------
module pipt_edge_pipe
	import pipt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tok_t                 tok_s1,
	input  wire vertex_t              rd_data,
	input  wire logic signed [XW-1:0] tx,
	input  wire logic signed [YW-1:0] ty,
	output res_t                      res
);

	logic signed [XW-1:0]  xi;
	logic signed [YW-1:0]  yi;
	logic signed [XW-1:0]  prev_x_q;
	logic signed [YW-1:0]  prev_y_q;
	logic signed [DXW-1:0] dxt_c;
	logic signed [DXW-1:0] dxe_c;
	logic signed [DYW-1:0] dy_c;
	logic signed [DYW-1:0] dty_c;
	logic                  straddle_c;

	tok_t                  tok_s2;
	logic                  straddle_s2;
	logic signed [DXW-1:0] dxt_s2;
	logic signed [DXW-1:0] dxe_s2;
	logic signed [DYW-1:0] dy_s2;
	logic signed [DYW-1:0] dty_s2;

	tok_t                  tok_s3;
	logic                  straddle_s3;
	logic                  dypos_s3;
	logic signed [PW-1:0]  lhs_s3;
	logic signed [PW-1:0]  rhs_s3;

	logic                  toggle;
	logic                  inside_q;
	logic                  inside_nxt;
	logic                  strobe_q;
	logic                  res_q;

	assign xi = $signed(rd_data.x);
	assign yi = $signed(rd_data.y);

	// vertex i from memory, vertex j held from the previous read
	assign dxt_c = $signed({tx[XW-1], tx}) - $signed({xi[XW-1], xi});
	assign dxe_c = $signed({prev_x_q[XW-1], prev_x_q}) - $signed({xi[XW-1], xi});
	assign dy_c  = $signed({prev_y_q[YW-1], prev_y_q}) - $signed({yi[YW-1], yi});
	assign dty_c = $signed({ty[YW-1], ty}) - $signed({yi[YW-1], yi});
	assign straddle_c = !tok_s1.first && ((yi > ty) != (prev_y_q > ty));

	assign toggle = straddle_s3 && (dypos_s3 ? (lhs_s3 < rhs_s3) : (lhs_s3 > rhs_s3));
	assign inside_nxt = (tok_s3.first ? 1'b0 : inside_q) ^ toggle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2   <= '0;
			tok_s3   <= '0;
			inside_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			tok_s2   <= tok_s1;
			tok_s3   <= tok_s2;
			strobe_q <= tok_s3.valid && tok_s3.last;
			if (tok_s3.valid) begin
				inside_q <= inside_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_s1.valid) begin
			prev_x_q <= xi;
			prev_y_q <= yi;
		end
		straddle_s2 <= straddle_c;
		dxt_s2      <= dxt_c;
		dxe_s2      <= dxe_c;
		dy_s2       <= dy_c;
		dty_s2      <= dty_c;
		straddle_s3 <= straddle_s2;
		dypos_s3    <= !dy_s2[DYW-1];
		lhs_s3      <= dxt_s2 * dy_s2;
		rhs_s3      <= dxe_s2 * dty_s2;
		if (tok_s3.valid && tok_s3.last) begin
			res_q <= inside_nxt;
		end
	end

	assign res.fin    = tok_s3.valid && tok_s3.last;
	assign res.strobe = strobe_q;
	assign res.hit    = res_q;

endmodule
`default_nettype wire

// ===== hdl/point_in_polygon_test_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit
// Even-odd ray casting geofence test over a stored polygon.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A load word writes one
// vertex and gives no result; busy stays low. A test word walks n =
// min(vertex_count, MAX_VERTICES) edges, one vertex read from the store per
// cycle: the result is on inside_res with done high for one cycle, and busy
// drops in that same cycle, so no new word is taken while a test is in
// progress. done cannot be held off: the result must be taken when shown.
// vertex_count may only be written while busy is low.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit
	import pipt_pkg::*;
#(
	parameter int MAX_VERTICES = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   opcode,
	input  wire logic [IDXW-1:0]        vertex_index,
	input  wire logic signed [XW-1:0]   coord_x,
	input  wire logic signed [YW-1:0]   coord_y,
	output logic                        done,
	output logic                        inside_res,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFGW-1:0]        cfg_data
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_WAIT
	} state_t;

	state_t               state_q;
	logic                 busy_q;
	logic [CFGW-1:0]      vertex_count_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        n_sat;
	logic signed [XW-1:0] tx_q;
	logic signed [YW-1:0] ty_q;
	tok_t                 tok_s1;

	logic                 accept;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	vertex_t              wr_data;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	vertex_t              rd_data;
	res_t                 res;

	assign cfg_ready = 1'b1;
	assign busy      = busy_q;
	assign accept    = start && !busy_q;

	assign n_sat = (32'(vertex_count_q) > MAX_VERTICES) ? CW'(MAX_VERTICES)
		: CW'(vertex_count_q);

	assign wr_en     = accept && (opcode == OP_LOAD) && (32'(vertex_index) < MAX_VERTICES);
	assign wr_addr   = AW'(vertex_index);
	assign wr_data.x = coord_x;
	assign wr_data.y = coord_y;

	// first read fetches the closing vertex n-1, then vertices 0..n-1
	assign rd_en   = (state_q == ST_WALK);
	assign rd_addr = (cnt_q == '0) ? ((n_q == '0) ? '0 : AW'(n_q - 1'b1))
		: AW'(cnt_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			vertex_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			n_q     <= '0;
			cnt_q   <= '0;
			tok_s1  <= '0;
		end else begin
			tok_s1.valid <= rd_en;
			tok_s1.first <= (cnt_q == '0);
			tok_s1.last  <= (cnt_q == n_q);
			case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == OP_TEST)) begin
						state_q <= ST_WALK;
						busy_q  <= 1'b1;
						n_q     <= n_sat;
						cnt_q   <= '0;
					end
				end
				ST_WALK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == n_q) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (res.fin) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (opcode == OP_TEST)) begin
			tx_q <= coord_x;
			ty_q <= coord_y;
		end
	end

	pipt_vertex_mem #(
		.DEPTH (MAX_VERTICES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pipt_edge_pipe u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok_s1  (tok_s1),
		.rd_data (rd_data),
		.tx      (tx_q),
		.ty      (ty_q),
		.res     (res)
	);

	assign done       = res.strobe;
	assign inside_res = res.hit;

endmodule
`default_nettype wire
